FILE: src/adf_pkg.sv
// Package for the ASCII decimal to fixed-point converter.
// Holds widths, character codes, powers of ten and the result type.
// No dependencies.
package adf_pkg;

    localparam int ADF_FRAC_BITS       = 32;
    localparam int ADF_MAX_FRAC_DIGITS = 10;
    localparam int ADF_CHAR_W          = 8;
    localparam int ADF_VALUE_W         = 64;
    localparam int ADF_INT_W           = 60;
    localparam int ADF_Q_W             = 62;
    localparam int ADF_CNT_W           = 4;
    localparam int ADF_DIGIT_W         = 9;

    localparam logic signed [ADF_INT_W-1:0] ADF_INT_LIMIT = ADF_INT_W'(64'sd1 <<< 58);

    localparam logic [ADF_CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [ADF_CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [ADF_CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [ADF_CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [ADF_CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [ADF_CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [ADF_CHAR_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [ADF_CHAR_W-1:0] CH_ZERO  = 8'h30;

    localparam logic [63:0] ADF_POW10 [17] = '{
        64'd1,
        64'd10,
        64'd100,
        64'd1000,
        64'd10000,
        64'd100000,
        64'd1000000,
        64'd10000000,
        64'd100000000,
        64'd1000000000,
        64'd10000000000,
        64'd100000000000,
        64'd1000000000000,
        64'd10000000000000,
        64'd100000000000000,
        64'd1000000000000000,
        64'd10000000000000000
    };

    typedef struct packed {
        logic [ADF_VALUE_W-1:0] value;
        logic                   overflow;
    } t_result;

endpackage

FILE: src/adf_emit.sv
// Final conversion of the accumulated integral and fraction parts to a
// saturated two's complement fixed-point word. Combinational.
// Depends on adf_pkg.
module adf_emit
    import adf_pkg::*;
#(
    parameter int FRAC_BITS = ADF_FRAC_BITS
) (
    input  logic                          i_negative,
    input  logic signed [ADF_INT_W-1:0]   i_integral,
    input  logic signed [FRAC_BITS+9:0]   i_fraction,
    output t_result                       o_result
);

    localparam int FW = FRAC_BITS + 10;
    localparam logic signed [ADF_Q_W-1:0] QMAX =
        ADF_Q_W'((64'sd1 <<< (63 - FRAC_BITS)) - 64'sd1);
    localparam logic signed [ADF_Q_W-1:0] QMIN = -QMAX - ADF_Q_W'(1);

    logic signed [FW-FRAC_BITS-1:0] w_q0;
    logic        [FRAC_BITS-1:0]    w_r;
    logic signed [ADF_Q_W-1:0]      w_q;
    logic signed [ADF_Q_W-1:0]      w_qs;
    logic        [FRAC_BITS-1:0]    w_rs;

    assign w_q0 = (FW-FRAC_BITS)'(i_fraction >>> FRAC_BITS);
    assign w_r  = i_fraction[FRAC_BITS-1:0];
    assign w_q  = ADF_Q_W'(i_integral) + ADF_Q_W'(w_q0);

    always_comb begin
        if (i_negative) begin
            w_qs = (w_r != '0) ? ~w_q : -w_q;
            w_rs = -w_r;
        end else begin
            w_qs = w_q;
            w_rs = w_r;
        end
    end

    always_comb begin
        if (w_qs > QMAX) begin
            o_result.value    = {1'b0, {(ADF_VALUE_W-1){1'b1}}};
            o_result.overflow = 1'b1;
        end else if (w_qs < QMIN) begin
            o_result.value    = {1'b1, {(ADF_VALUE_W-1){1'b0}}};
            o_result.overflow = 1'b1;
        end else begin
            o_result.value    = {w_qs[ADF_VALUE_W-FRAC_BITS-1:0], w_rs};
            o_result.overflow = 1'b0;
        end
    end

endmodule

FILE: src/ascii_decimal_to_fixed_unit.sv
// ASCII decimal string to signed fixed-point converter, top level.
// Input register, per-character state update and a result register.
// Depends on adf_pkg and adf_emit.
//
//  channel  | direction | tdata                     | tuser
//  ---------+-----------+---------------------------+-----------
//  s        | in        | [7:0] char_code           | -
//  m        | out       | [63:0] value (Q31.32)     | [0] overflow
//
// One character beat per cycle unless a zero character stalls; the state and result registers
// load directly from the input register, and a consumed zero character raises the result beat.
// Reset is synchronous, active low, and returns the parser to whitespace skip.
// A zero character stalls in the input register only while a previous result
// is still waiting on the m side; other characters never stall.
module ascii_decimal_to_fixed_unit
    import adf_pkg::*;
#(
    parameter int FRAC_BITS = ADF_FRAC_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [ADF_CHAR_W-1:0]  i_s_tdata,   // [7:0] char_code
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [ADF_VALUE_W-1:0] o_m_tdata,   // [63:0] value
    output logic                   o_m_tuser    // [0] overflow
);

    localparam int FW = FRAC_BITS + 10;
    localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_INT,
        PH_FRAC
    } t_phase;

    logic                         r_in_valid;
    logic [ADF_CHAR_W-1:0]        r_char;
    t_phase                       r_phase, n_phase;
    logic                         r_negative, n_negative;
    logic signed [ADF_INT_W-1:0]  r_int, n_int;
    logic signed [FW-1:0]         r_frac, n_frac;
    logic [ADF_CNT_W-1:0]         r_frac_cnt, n_frac_cnt;
    logic                         r_out_valid;
    t_result                      r_result;

    logic                         w_consume;
    logic                         w_emit;
    logic signed [ADF_DIGIT_W-1:0] w_digit;
    logic signed [63:0]           w_int_ext;
    logic signed [63:0]           w_int_next;
    logic signed [ADF_INT_W-1:0]  w_int_sat;
    logic [FRAC_BITS-1:0]         w_frac_w [1 << ADF_CNT_W];
    logic signed [FW-1:0]         w_frac_add;
    logic                         w_is_ws;
    t_result                      w_result;

    for (genvar g = 0; g < (1 << ADF_CNT_W); g++) begin : g_weight
        localparam logic [63:0] W = ONE / ADF_POW10[g+1];
        assign w_frac_w[g] = FRAC_BITS'(W);
    end

    assign w_consume  = !(r_char == CH_NUL && r_out_valid && !i_m_tready);
    assign o_s_tready = !r_in_valid || w_consume;
    assign w_emit     = r_in_valid && w_consume && r_char == CH_NUL;

    assign w_digit    = $signed({1'b0, r_char}) - $signed({1'b0, CH_ZERO});
    assign w_int_ext  = 64'(r_int);
    assign w_int_next = (w_int_ext <<< 3) + (w_int_ext <<< 1) + 64'(w_digit);
    assign w_is_ws    = r_char == CH_SPACE || r_char == CH_TAB || r_char == CH_LF;
    assign w_frac_add = FW'(w_digit) * FW'($signed({1'b0, w_frac_w[r_frac_cnt]}));

    always_comb begin
        if (w_int_next > 64'(ADF_INT_LIMIT)) begin
            w_int_sat = ADF_INT_LIMIT;
        end else if (w_int_next < -64'(ADF_INT_LIMIT)) begin
            w_int_sat = -ADF_INT_LIMIT;
        end else begin
            w_int_sat = ADF_INT_W'(w_int_next);
        end
    end

    always_comb begin
        n_phase    = r_phase;
        n_negative = r_negative;
        n_int      = r_int;
        n_frac     = r_frac;
        n_frac_cnt = r_frac_cnt;
        if (r_in_valid && w_consume) begin
            if (r_char == CH_NUL) begin
                n_phase    = PH_SPACE;
                n_negative = 1'b0;
                n_int      = '0;
                n_frac     = '0;
                n_frac_cnt = '0;
            end else begin
                unique case (r_phase)
                    PH_SPACE, PH_SIGN: begin
                        if (r_phase == PH_SPACE && w_is_ws) begin
                            n_phase = r_phase;
                        end else if (r_char == CH_PLUS || r_char == CH_MINUS) begin
                            n_negative = r_negative ^ (r_char == CH_MINUS);
                            n_phase    = PH_SIGN;
                        end else if (r_char == CH_DOT) begin
                            n_phase = PH_FRAC;
                        end else begin
                            n_int   = w_int_sat;
                            n_phase = PH_INT;
                        end
                    end
                    PH_INT: begin
                        if (r_char == CH_DOT) begin
                            n_phase = PH_FRAC;
                        end else begin
                            n_int = w_int_sat;
                        end
                    end
                    PH_FRAC: begin
                        if (r_frac_cnt < ADF_CNT_W'(ADF_MAX_FRAC_DIGITS)) begin
                            n_frac_cnt = r_frac_cnt + ADF_CNT_W'(1);
                            n_frac     = r_frac + w_frac_add;
                        end
                    end
                    default: begin
                        n_phase = PH_SPACE;
                    end
                endcase
            end
        end
    end

    adf_emit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_emit (
        .i_negative (r_negative),
        .i_integral (r_int),
        .i_fraction (r_frac),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_phase     <= PH_SPACE;
            r_negative  <= 1'b0;
            r_int       <= '0;
            r_frac      <= '0;
            r_frac_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            r_phase    <= n_phase;
            r_negative <= n_negative;
            r_int      <= n_int;
            r_frac     <= n_frac;
            r_frac_cnt <= n_frac_cnt;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_char <= i_s_tdata;
        end
        if (w_emit) begin
            r_result <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_result.value;
    assign o_m_tuser  = r_result.overflow;

`ifndef NO_ASSERTIONS
    a_result_from_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_char == CH_NUL))
        else $error("result beat without a terminating character");

    a_int_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_int <= ADF_INT_LIMIT && r_int >= -ADF_INT_LIMIT)
        else $error("integral accumulator beyond saturation limit");

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frac_cnt <= ADF_CNT_W'(ADF_MAX_FRAC_DIGITS))
        else $error("fraction digit count beyond limit");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_consume) |=> (r_in_valid && $stable(r_char)))
        else $error("stalled character lost");

    a_clear_after_nul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (r_phase == PH_SPACE && r_frac_cnt == '0 && r_int == '0
                    && r_frac == '0 && !r_negative))
        else $error("parser state not cleared after result");
`endif

endmodule
